[rtl/imhq_pkg.sv]
// ============================================================================
// imhq_pkg: shared constants and types of the indexed min-heap queue
// Request modes, status codes, field widths and the result record.
// ============================================================================
`default_nettype none

package imhq_pkg;

    localparam int CAPACITY_DEF      = 256;
    localparam int HANDLE_COUNT_DEF  = 256;
    localparam int PRIORITY_BITS_DEF = 32;

    localparam int MODE_W     = 2;
    localparam int HANDLE_W   = 8;
    localparam int PRIO_REQ_W = 32;
    localparam int STATUS_W   = 3;
    localparam int OCC_W      = 9;

    localparam logic [MODE_W-1:0] MODE_PUSH     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEC_KEY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_KEY_LARGER = 3'd5;

    typedef struct packed {
        logic [HANDLE_W-1:0] out_handle;
        logic                present;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/imhq_if.sv]
// ============================================================================
// imhq_req_if / imhq_rsp_if: request and response channels
// Valid/ready channels; one transaction per edge with valid and ready high.
// ============================================================================
`default_nettype none

interface imhq_req_if
    import imhq_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [HANDLE_W-1:0]   handle;
    logic [PRIO_REQ_W-1:0] priority_req;

    modport source (output valid, output mode, output handle, output priority_req,
                    input ready);
    modport sink   (input valid, input mode, input handle, input priority_req,
                    output ready);
endinterface

interface imhq_rsp_if
    import imhq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] out_handle;
    logic                present;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output out_handle, output present, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_handle, input present, input status,
                    input occupancy, output ready);
endinterface

`default_nettype wire

[rtl/imhq_ram.sv]
// ============================================================================
// imhq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ============================================================================
`default_nettype none

module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/imhq_core.sv]
// ============================================================================
// imhq_core: heap sequencer
// Decodes a request, walks the heap one level per pass with a single compare
// path, moves the hole and keeps the handle-to-slot map in step.
// ============================================================================
`default_nettype none

module imhq_core
    import imhq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int HANDLE_COUNT  = HANDLE_COUNT_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    localparam int SIDX_W = $clog2(CAPACITY),
    localparam int HIDX_W = $clog2(HANDLE_COUNT),
    localparam int SLOT_W = PRIORITY_BITS + HANDLE_W,
    localparam int MAP_W  = SIDX_W + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    imhq_req_if.sink               req,
    input  wire logic              rsp_free,
    output logic                   rsp_load,
    output rsp_t                   rsp_data,
    output logic                   s_we,
    output logic [SIDX_W-1:0]      s_waddr,
    output logic [SLOT_W-1:0]      s_wdata,
    output logic [SIDX_W-1:0]      s_raddr,
    input  wire logic [SLOT_W-1:0] s_rdata,
    output logic                   m_we,
    output logic [HIDX_W-1:0]      m_waddr,
    output logic [MAP_W-1:0]       m_wdata,
    output logic [HIDX_W-1:0]      m_raddr,
    input  wire logic [MAP_W-1:0]  m_rdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = SIDX_W + 2;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_LOOK     = 11'b000_0000_0100,
        S_POP_LAST = 11'b000_0000_1000,
        S_DK_RD    = 11'b000_0001_0000,
        S_UP_RD    = 11'b000_0010_0000,
        S_UP_CMP   = 11'b000_0100_0000,
        S_DN_L     = 11'b000_1000_0000,
        S_DN_R     = 11'b001_0000_0000,
        S_DN_CMP   = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [HIDX_W-1:0]         clr_reg, clr_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic [HANDLE_W-1:0]       handle_reg, handle_next;
    logic [PRIORITY_BITS-1:0]  prio_reg, prio_next;
    logic [SIDX_W-1:0]         idx_reg, idx_next;
    logic [PRIORITY_BITS-1:0]  cur_prio_reg, cur_prio_next;
    logic [HANDLE_W-1:0]       cur_handle_reg, cur_handle_next;
    logic [SLOT_W-1:0]         left_reg, left_next;
    logic [HANDLE_W-1:0]       res_handle_reg, res_handle_next;
    logic                      res_present_reg, res_present_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;

    logic [PRIORITY_BITS-1:0]  rd_prio;
    logic [HANDLE_W-1:0]       rd_handle;
    logic [PRIORITY_BITS-1:0]  left_prio;
    logic [HANDLE_W-1:0]       left_handle;
    logic                      hvalid;
    logic                      queued;
    logic [SIDX_W-1:0]         map_slot;
    logic [SIDX_W-1:0]         up_slot;
    logic [CW-1:0]             left_w;
    logic [CW-1:0]             right_w;
    logic [CW-1:0]             cnt_w;
    logic                      pick_left;
    logic                      pick_right;
    logic [PRIORITY_BITS-1:0]  best_prio;

    assign rd_prio     = s_rdata[SLOT_W-1 -: PRIORITY_BITS];
    assign rd_handle   = s_rdata[HANDLE_W-1:0];
    assign left_prio   = left_reg[SLOT_W-1 -: PRIORITY_BITS];
    assign left_handle = left_reg[HANDLE_W-1:0];
    assign hvalid      = 32'(handle_reg) < HANDLE_COUNT;
    assign queued      = hvalid && m_rdata[SIDX_W];
    assign map_slot    = m_rdata[SIDX_W-1:0];
    assign up_slot     = (idx_reg - SIDX_W'(1)) >> 1;
    assign left_w      = CW'({idx_reg, 1'b1});
    assign right_w     = left_w + CW'(1);
    assign cnt_w       = CW'(count_reg);
    assign pick_left   = left_prio < cur_prio_reg;
    assign best_prio   = pick_left ? left_prio : cur_prio_reg;
    assign pick_right  = (right_w < cnt_w) && (rd_prio < best_prio);

    assign rsp_data.out_handle = res_handle_reg;
    assign rsp_data.present    = res_present_reg;
    assign rsp_data.status     = res_status_reg;
    assign rsp_data.occupancy  = OCC_W'(count_reg);

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        count_next       = count_reg;
        mode_next        = mode_reg;
        handle_next      = handle_reg;
        prio_next        = prio_reg;
        idx_next         = idx_reg;
        cur_prio_next    = cur_prio_reg;
        cur_handle_next  = cur_handle_reg;
        left_next        = left_reg;
        res_handle_next  = res_handle_reg;
        res_present_next = res_present_reg;
        res_status_next  = res_status_reg;
        req.ready        = 1'b0;
        rsp_load         = 1'b0;
        s_we             = 1'b0;
        s_waddr          = idx_reg;
        s_wdata          = {cur_prio_reg, cur_handle_reg};
        s_raddr          = '0;
        m_we             = 1'b0;
        m_waddr          = HIDX_W'(cur_handle_reg);
        m_wdata          = {1'b1, idx_reg};
        m_raddr          = HIDX_W'(handle_reg);

        case (state_reg)
            S_CLEAR:
            begin
                m_we     = 1'b1;
                m_waddr  = clr_reg;
                m_wdata  = '0;
                clr_next = clr_reg + HIDX_W'(1);
                if (clr_reg == HIDX_W'(HANDLE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                m_raddr   = HIDX_W'(req.handle);
                if (req.valid)
                begin
                    mode_next        = req.mode;
                    handle_next      = req.handle;
                    prio_next        = PRIORITY_BITS'(req.priority_req);
                    res_handle_next  = '0;
                    res_present_next = 1'b0;
                    res_status_next  = ST_OK;
                    state_next       = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_RESP;
                case (mode_reg)
                    MODE_PUSH:
                    begin
                        if (!hvalid)
                        begin
                            res_status_next = ST_ABSENT;
                        end
                        else if (queued)
                        begin
                            res_status_next = ST_PRESENT;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cur_prio_next   = prio_reg;
                            cur_handle_next = handle_reg;
                            idx_next        = SIDX_W'(count_reg);
                            count_next      = count_reg + CNT_W'(1);
                            state_next      = S_UP_RD;
                        end
                    end
                    MODE_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            res_handle_next = rd_handle;
                            m_we            = 1'b1;
                            m_waddr         = HIDX_W'(rd_handle);
                            m_wdata         = '0;
                            count_next      = count_reg - CNT_W'(1);
                            if (count_reg != CNT_W'(1))
                            begin
                                s_raddr    = SIDX_W'(count_reg - CNT_W'(1));
                                state_next = S_POP_LAST;
                            end
                        end
                    end
                    MODE_DEC_KEY:
                    begin
                        if (!queued || (CNT_W'(map_slot) >= count_reg))
                        begin
                            res_status_next = ST_ABSENT;
                        end
                        else
                        begin
                            idx_next   = map_slot;
                            s_raddr    = map_slot;
                            state_next = S_DK_RD;
                        end
                    end
                    MODE_CONTAINS:
                    begin
                        res_present_next = queued;
                    end
                    default:
                    begin
                        res_present_next = 1'b0;
                    end
                endcase
            end
            S_POP_LAST:
            begin
                cur_prio_next   = rd_prio;
                cur_handle_next = rd_handle;
                idx_next        = '0;
                state_next      = S_DN_L;
            end
            S_DK_RD:
            begin
                if (prio_reg > rd_prio)
                begin
                    res_status_next = ST_KEY_LARGER;
                    state_next      = S_RESP;
                end
                else
                begin
                    cur_prio_next   = prio_reg;
                    cur_handle_next = handle_reg;
                    state_next      = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    s_we       = 1'b1;
                    m_we       = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    s_raddr    = up_slot;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                s_we = 1'b1;
                m_we = 1'b1;
                if (cur_prio_reg < rd_prio)
                begin
                    s_wdata    = s_rdata;
                    m_waddr    = HIDX_W'(rd_handle);
                    idx_next   = up_slot;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_DN_L:
            begin
                if (left_w >= cnt_w)
                begin
                    s_we       = 1'b1;
                    m_we       = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    s_raddr    = SIDX_W'(left_w);
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                left_next = s_rdata;
                if (right_w < cnt_w)
                begin
                    s_raddr = SIDX_W'(right_w);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                s_we = 1'b1;
                m_we = 1'b1;
                if (pick_right)
                begin
                    s_wdata    = s_rdata;
                    m_waddr    = HIDX_W'(rd_handle);
                    idx_next   = SIDX_W'(right_w);
                    state_next = S_DN_L;
                end
                else if (pick_left)
                begin
                    s_wdata    = left_reg;
                    m_waddr    = HIDX_W'(left_handle);
                    idx_next   = SIDX_W'(left_w);
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        handle_reg      <= handle_next;
        prio_reg        <= prio_next;
        idx_reg         <= idx_next;
        cur_prio_reg    <= cur_prio_next;
        cur_handle_reg  <= cur_handle_next;
        left_reg        <= left_next;
        res_handle_reg  <= res_handle_next;
        res_present_reg <= res_present_next;
        res_status_reg  <= res_status_next;
    end

endmodule

`default_nettype wire

[rtl/indexed_min_heap_queue.sv]
// ============================================================================
// indexed_min_heap_queue: addressable binary min-heap with position map
// Usage:
//   req channel (sink): mode, handle, priority_req. Modes are push, pop,
//   key decrease and contains. rsp channel (source): out_handle, present,
//   status, occupancy; exactly one response transaction per request.
//   req.ready is high only while the sequencer is idle; one request is in
//   flight at a time. Contains and requests that fail their lookup finish
//   without moving the heap; a key decrease with a larger key stops after
//   reading its slot. Push sifts the new entry up, a good key decrease
//   sifts up from the handle's slot, and pop moves the last entry to the
//   root and sifts it down, unless the pop empties the heap.
//   Each heap level moved needs its own reads of the single-read-port
//   slot RAM before the one compare path can decide the move.
//   Reset: heap empties; the position map is then swept to absent, one
//   handle per cycle through every handle, with req.ready low throughout.
//   The response sits in an output register; while rsp.ready is low the
//   block still takes one more request and holds its result until the
//   register frees.
// ============================================================================
`default_nettype none

module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int HANDLE_COUNT  = HANDLE_COUNT_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    imhq_req_if.sink   req,
    imhq_rsp_if.source rsp
);

    localparam int SIDX_W = $clog2(CAPACITY);
    localparam int HIDX_W = $clog2(HANDLE_COUNT);
    localparam int SLOT_W = PRIORITY_BITS + HANDLE_W;
    localparam int MAP_W  = SIDX_W + 1;

    logic              s_we;
    logic [SIDX_W-1:0] s_waddr;
    logic [SLOT_W-1:0] s_wdata;
    logic [SIDX_W-1:0] s_raddr;
    logic [SLOT_W-1:0] s_rdata;
    logic              m_we;
    logic [HIDX_W-1:0] m_waddr;
    logic [MAP_W-1:0]  m_wdata;
    logic [HIDX_W-1:0] m_raddr;
    logic [MAP_W-1:0]  m_rdata;

    logic rsp_free;
    logic rsp_load;
    rsp_t rsp_data;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_data_reg;

    imhq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    imhq_ram #(
        .WIDTH (MAP_W),
        .DEPTH (HANDLE_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    imhq_core #(
        .CAPACITY      (CAPACITY),
        .HANDLE_COUNT  (HANDLE_COUNT),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp_free (rsp_free),
        .rsp_load (rsp_load),
        .rsp_data (rsp_data),
        .s_we     (s_we),
        .s_waddr  (s_waddr),
        .s_wdata  (s_wdata),
        .s_raddr  (s_raddr),
        .s_rdata  (s_rdata),
        .m_we     (m_we),
        .m_waddr  (m_waddr),
        .m_wdata  (m_wdata),
        .m_raddr  (m_raddr),
        .m_rdata  (m_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_data;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.out_handle = rsp_data_reg.out_handle;
    assign rsp.present    = rsp_data_reg.present;
    assign rsp.status     = rsp_data_reg.status;
    assign rsp.occupancy  = rsp_data_reg.occupancy;

endmodule

`default_nettype wire
